@@ hdl/binary_stl_deframer_macros.svh @@
// Assertion macros for the binary STL deframer.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef BINARY_STL_DEFRAMER_MACROS_SVH
`define BINARY_STL_DEFRAMER_MACROS_SVH

`ifndef SYNTH
// Check a property on every rising clock edge outside reset.
`define BSD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("binary_stl_deframer: assertion failed");
// Check a property on every rising clock edge, reset included.
`define BSD_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("binary_stl_deframer: assertion failed");
`else
`define BSD_ASSERT(lbl, clk, rst, prop)
`define BSD_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ hdl/bstl_pkg.sv @@
// Shared types, constants and the record slot decoder for the binary STL deframer.
// No dependencies; used by bstl_parser, bstl_outbuf and binary_stl_deframer.
`default_nettype none

package bstl_pkg;

   localparam logic [6:0] HEADER_BYTES   = 7'd80;
   localparam logic [6:0] PREAMBLE_BYTES = 7'd84;
   localparam logic [5:0] RECORD_BYTES   = 6'd50;
   localparam logic [5:0] LAST_OFFSET    = RECORD_BYTES - 6'd1;
   localparam logic [5:0] NORMAL_BYTES   = 6'd12;
   localparam logic [5:0] CORNER_BYTES   = 6'd12;
   localparam logic [5:0] VERTEX_END     = NORMAL_BYTES + 6'd36;

   typedef enum logic [1:0] {
      KIND_VERTEX       = 2'd0,
      KIND_END_OK       = 2'd1,
      KIND_END_SHORT    = 2'd2,
      KIND_END_MISMATCH = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] x_bits;
      logic [31:0] y_bits;
      logic [31:0] z_bits;
      logic [1:0]  corner;
      logic [31:0] triangle_index;
      logic [31:0] declared_triangles;
      logic        last;
   } result_type;

   // Where a record byte falls among the three corner vertices.
   typedef struct packed {
      logic       active;
      logic [1:0] corner;
      logic [1:0] comp;
      logic [1:0] pos;
   } slot_type;

   function automatic slot_type decode_slot(input logic [5:0] offset);
      slot_type   s;
      logic [5:0] rel;
      logic [5:0] corner_byte;
      rel      = offset - NORMAL_BYTES;
      s.active = (offset >= NORMAL_BYTES) && (offset < VERTEX_END);
      if (rel < CORNER_BYTES) begin
         s.corner    = 2'd0;
         corner_byte = rel;
      end else if (rel < (CORNER_BYTES + CORNER_BYTES)) begin
         s.corner    = 2'd1;
         corner_byte = rel - CORNER_BYTES;
      end else begin
         s.corner    = 2'd2;
         corner_byte = rel - CORNER_BYTES - CORNER_BYTES;
      end
      s.comp = corner_byte[3:2];
      s.pos  = corner_byte[1:0];
      return s;
   endfunction

endpackage

`default_nettype wire

@@ hdl/bstl_parser.sv @@
// Byte-level framing state of the binary STL deframer: preamble, records, end status.
// Depends on bstl_pkg and binary_stl_deframer_macros.svh.
`default_nettype none
`include "binary_stl_deframer_macros.svh"

module bstl_parser (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire logic [7:0]           data_byte,
   input  wire logic                 end_marker,
   output logic                      res_valid,
   output bstl_pkg::result_type      res
);

   logic [6:0]  header_position_ff, header_position_in;
   logic [31:0] count_register_ff, count_register_in;
   logic [5:0]  record_offset_ff, record_offset_in;
   logic [31:0] triangles_done_ff, triangles_done_in;
   logic [23:0] word_assembly_ff, word_assembly_in;
   logic [31:0] held_x_ff, held_x_in;
   logic [31:0] held_y_ff, held_y_in;
   logic        excess_seen_ff, excess_seen_in;
   bstl_pkg::slot_type slot;

   assign slot = bstl_pkg::decode_slot(record_offset_ff);

   always_comb begin
      header_position_in = header_position_ff;
      count_register_in  = count_register_ff;
      record_offset_in   = record_offset_ff;
      triangles_done_in  = triangles_done_ff;
      word_assembly_in   = word_assembly_ff;
      held_x_in          = held_x_ff;
      held_y_in          = held_y_ff;
      excess_seen_in     = excess_seen_ff;
      res_valid          = 1'b0;
      res                = '0;
      if (accept) begin
         if (end_marker) begin
            res_valid = 1'b1;
            res.last  = 1'b1;
            if (header_position_ff < bstl_pkg::PREAMBLE_BYTES) begin
               res.kind = bstl_pkg::KIND_END_SHORT;
            end else begin
               res.declared_triangles = count_register_ff;
               if (excess_seen_ff || (record_offset_ff != '0) ||
                   (triangles_done_ff != count_register_ff)) begin
                  res.kind = bstl_pkg::KIND_END_MISMATCH;
               end else begin
                  res.kind = bstl_pkg::KIND_END_OK;
               end
            end
            // return to the start-of-file state
            header_position_in = '0;
            count_register_in  = '0;
            record_offset_in   = '0;
            triangles_done_in  = '0;
            word_assembly_in   = '0;
            held_x_in          = '0;
            held_y_in          = '0;
            excess_seen_in     = 1'b0;
         end else if (header_position_ff < bstl_pkg::PREAMBLE_BYTES) begin
            if (header_position_ff >= bstl_pkg::HEADER_BYTES) begin
               count_register_in = {data_byte, count_register_ff[31:8]};
            end
            header_position_in = header_position_ff + 7'd1;
         end else if ((record_offset_ff == '0) &&
                      (triangles_done_ff == count_register_ff)) begin
            // drop bytes past the declared records
            excess_seen_in = 1'b1;
         end else begin
            if (slot.active) begin
               unique case (slot.pos)
                  2'd0: word_assembly_in = {16'd0, data_byte};
                  2'd1: word_assembly_in = word_assembly_ff | {8'd0, data_byte, 8'd0};
                  2'd2: word_assembly_in = word_assembly_ff | {data_byte, 16'd0};
                  default: begin
                     unique case (slot.comp)
                        2'd0: held_x_in = {data_byte, word_assembly_ff};
                        2'd1: held_y_in = {data_byte, word_assembly_ff};
                        default: begin
                           res_valid          = 1'b1;
                           res.kind           = bstl_pkg::KIND_VERTEX;
                           res.x_bits         = held_x_ff;
                           res.y_bits         = held_y_ff;
                           res.z_bits         = {data_byte, word_assembly_ff};
                           res.corner         = slot.corner;
                           res.triangle_index = triangles_done_ff;
                        end
                     endcase
                  end
               endcase
            end
            if (record_offset_ff == bstl_pkg::LAST_OFFSET) begin
               record_offset_in  = '0;
               triangles_done_in = triangles_done_ff + 32'd1;
            end else begin
               record_offset_in  = record_offset_ff + 6'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_position_ff <= '0;
         count_register_ff  <= '0;
         record_offset_ff   <= '0;
         triangles_done_ff  <= '0;
         word_assembly_ff   <= '0;
         held_x_ff          <= '0;
         held_y_ff          <= '0;
         excess_seen_ff     <= 1'b0;
      end else begin
         header_position_ff <= header_position_in;
         count_register_ff  <= count_register_in;
         record_offset_ff   <= record_offset_in;
         triangles_done_ff  <= triangles_done_in;
         word_assembly_ff   <= word_assembly_in;
         held_x_ff          <= held_x_in;
         held_y_ff          <= held_y_in;
         excess_seen_ff     <= excess_seen_in;
      end
   end

   `BSD_ASSERT(a_offset_range, clock, reset, record_offset_ff < bstl_pkg::RECORD_BYTES)
   `BSD_ASSERT(a_preamble_cap, clock, reset, header_position_ff <= bstl_pkg::PREAMBLE_BYTES)
   `BSD_ASSERT(a_no_records_in_preamble, clock, reset, (header_position_ff < bstl_pkg::PREAMBLE_BYTES) |-> ((record_offset_ff == '0) && (triangles_done_ff == '0) && !excess_seen_ff))
   `BSD_ASSERT(a_done_within_count, clock, reset, triangles_done_ff <= count_register_ff)
   `BSD_ASSERT(a_end_clears, clock, reset, (accept && end_marker) |=> ((header_position_ff == '0) && (count_register_ff == '0)))

endmodule

`default_nettype wire

@@ hdl/bstl_outbuf.sv @@
// Two-entry result register with skid slot; decouples the request side from a stalled receiver.
// Depends on bstl_pkg and binary_stl_deframer_macros.svh.
`default_nettype none
`include "binary_stl_deframer_macros.svh"

module bstl_outbuf (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire bstl_pkg::result_type push_data,
   output logic                      can_accept,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output bstl_pkg::result_type      out_data
);

   logic                 main_valid_ff, main_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   bstl_pkg::result_type main_data_ff, main_data_in;
   bstl_pkg::result_type skid_data_ff, skid_data_in;
   logic                 pop;

   assign pop        = main_valid_ff && out_ready;
   assign can_accept = !skid_valid_ff;
   assign out_valid  = main_valid_ff;
   assign out_data   = main_data_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (pop || !main_valid_ff) begin
         if (skid_valid_ff) begin
            // advance the skid entry, refill it with any new request
            main_valid_in = 1'b1;
            main_data_in  = skid_data_ff;
            skid_valid_in = push;
            skid_data_in  = push_data;
         end else begin
            main_valid_in = push;
            main_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   `BSD_ASSERT(a_skid_behind_main, clock, reset, skid_valid_ff |-> main_valid_ff)
   `BSD_ASSERT(a_no_push_when_full, clock, reset, skid_valid_ff |-> !push)
   `BSD_ASSERT(a_held_result_stays, clock, reset,
               (main_valid_ff && !out_ready) |=> (main_valid_ff && $stable(main_data_ff)))

endmodule

`default_nettype wire

@@ hdl/binary_stl_deframer.sv @@
// Binary STL deframer: byte stream in, vertex and end-status results out.
// Depends on bstl_pkg, bstl_parser and bstl_outbuf.
//
// Usage:
//   The request channel (req_*) carries one file byte per request, then a
//   request with req_end_marker high that closes the file. The parser skips
//   the 80-byte header, takes the little-endian triangle count, and in each
//   50-byte record skips the normal and drops the attribute.
//   The result channel (rsp_*) gives one vertex per triangle corner, on the
//   byte that completes its z word, and one status result (rsp_last high)
//   per end marker: ok, too short, or size mismatch. Vertices go out before
//   the status, so the receiver discards them on an error status.
//   A result is registered in the result buffer before it reaches rsp_*.
//   Throughput: one request per cycle while req_ready is high; a byte
//   needs one counter step and a byte shift in the parser.
//   Stall: a two-entry result buffer holds results while rsp_ready is low;
//   req_ready drops only when both entries are full.
//   Reset: synchronous, clears the framing state and empties the buffer;
//   an end marker also returns the parser to its start-of-file state.
`default_nettype none

module binary_stl_deframer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_end_marker,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_kind,
   output logic [31:0]      rsp_x_bits,
   output logic [31:0]      rsp_y_bits,
   output logic [31:0]      rsp_z_bits,
   output logic [1:0]       rsp_corner,
   output logic [31:0]      rsp_triangle_index,
   output logic [31:0]      rsp_declared_triangles,
   output logic             rsp_last
);

   logic                 accept;
   logic                 res_valid;
   bstl_pkg::result_type res;
   bstl_pkg::result_type out_res;

   assign accept = req_valid && req_ready;

   bstl_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .end_marker (req_end_marker),
      .res_valid  (res_valid),
      .res        (res)
   );

   bstl_outbuf u_outbuf (
      .clock      (clock),
      .reset      (reset),
      .push       (res_valid),
      .push_data  (res),
      .can_accept (req_ready),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_data   (out_res)
   );

   assign rsp_kind               = out_res.kind;
   assign rsp_x_bits             = out_res.x_bits;
   assign rsp_y_bits             = out_res.y_bits;
   assign rsp_z_bits             = out_res.z_bits;
   assign rsp_corner             = out_res.corner;
   assign rsp_triangle_index     = out_res.triangle_index;
   assign rsp_declared_triangles = out_res.declared_triangles;
   assign rsp_last               = out_res.last;

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for binary_stl_deframer: drives STL byte streams and end markers.
// Depends on bstl_pkg for the result kinds, the result layout and the framing constants.
`default_nettype none

module tb_top;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_end_marker = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [31:0] rsp_x_bits;
   logic [31:0] rsp_y_bits;
   logic [31:0] rsp_z_bits;
   logic [1:0]  rsp_corner;
   logic [31:0] rsp_triangle_index;
   logic [31:0] rsp_declared_triangles;
   logic        rsp_last;

   binary_stl_deframer i_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_data_byte          (req_data_byte),
      .req_end_marker         (req_end_marker),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_kind               (rsp_kind),
      .rsp_x_bits             (rsp_x_bits),
      .rsp_y_bits             (rsp_y_bits),
      .rsp_z_bits             (rsp_z_bits),
      .rsp_corner             (rsp_corner),
      .rsp_triangle_index     (rsp_triangle_index),
      .rsp_declared_triangles (rsp_declared_triangles),
      .rsp_last               (rsp_last)
   );

   // Deframer state as predicted from accepted requests
   logic [6:0]  hdr_pos   = '0;
   logic [31:0] tri_count = '0;
   logic [5:0]  rec_off   = '0;
   logic [31:0] tri_done  = '0;
   logic [23:0] word_acc  = '0;
   logic [31:0] x_hold    = '0;
   logic [31:0] y_hold    = '0;
   logic        excess    = 1'b0;

   bstl_pkg::result_type expected_results[$];
   bstl_pkg::result_type head_result;
   int mismatches  = 0;
   int items_sent  = 0;
   int burst_left  = 0;
   int hold_cycles = 0;
   bit pace_on     = 1'b1;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("FAIL");
      $finish;
   end

   task automatic queue_expected(input bstl_pkg::result_type r);
      expected_results = {expected_results, r};
   endtask

   task automatic predict_item(input logic [7:0] b, input logic e);
      bstl_pkg::result_type r;
      int          rel;
      int          corner_byte;
      int          pos;
      int          comp;
      logic [31:0] word;
      r = '0;
      if (e) begin
         r.last = 1'b1;
         if (hdr_pos < bstl_pkg::PREAMBLE_BYTES) begin
            r.kind = bstl_pkg::KIND_END_SHORT;
         end else begin
            r.declared_triangles = tri_count;
            if (excess || rec_off != 0 || tri_done != tri_count)
               r.kind = bstl_pkg::KIND_END_MISMATCH;
            else
               r.kind = bstl_pkg::KIND_END_OK;
         end
         queue_expected(r);
         hdr_pos   = '0;
         tri_count = '0;
         rec_off   = '0;
         tri_done  = '0;
         word_acc  = '0;
         x_hold    = '0;
         y_hold    = '0;
         excess    = 1'b0;
      end else if (hdr_pos < bstl_pkg::PREAMBLE_BYTES) begin
         if (hdr_pos >= bstl_pkg::HEADER_BYTES)
            tri_count = {b, tri_count[31:8]};
         hdr_pos++;
      end else if (rec_off == 0 && tri_done == tri_count) begin
         // past the declared records: drop the byte
         excess = 1'b1;
      end else begin
         if (rec_off >= bstl_pkg::NORMAL_BYTES && rec_off < bstl_pkg::VERTEX_END) begin
            rel         = int'(rec_off) - int'(bstl_pkg::NORMAL_BYTES);
            corner_byte = rel % 12;
            pos         = corner_byte % 4;
            comp        = corner_byte / 4;
            if (pos == 0) begin
               word_acc = {16'h0000, b};
            end else if (pos < 3) begin
               word_acc = word_acc | (24'(b) << (8 * pos));
            end else begin
               word = {b, word_acc};
               if (comp == 0) begin
                  x_hold = word;
               end else if (comp == 1) begin
                  y_hold = word;
               end else begin
                  r.kind           = bstl_pkg::KIND_VERTEX;
                  r.x_bits         = x_hold;
                  r.y_bits         = y_hold;
                  r.z_bits         = word;
                  r.corner         = 2'(rel / 12);
                  r.triangle_index = tri_done;
                  queue_expected(r);
               end
            end
         end
         rec_off++;
         if (rec_off >= bstl_pkg::RECORD_BYTES) begin
            rec_off = '0;
            tri_done++;
         end
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual kind %0d", $time, rsp_kind);
            mismatches++;
         end else begin
            head_result = expected_results.pop_front();
            check_field("kind", 32'(head_result.kind), 32'(rsp_kind));
            check_field("x_bits", head_result.x_bits, rsp_x_bits);
            check_field("y_bits", head_result.y_bits, rsp_y_bits);
            check_field("z_bits", head_result.z_bits, rsp_z_bits);
            check_field("corner", 32'(head_result.corner), 32'(rsp_corner));
            check_field("triangle_index", head_result.triangle_index, rsp_triangle_index);
            check_field("declared_triangles", head_result.declared_triangles,
                        rsp_declared_triangles);
            check_field("last", 32'(head_result.last), 32'(rsp_last));
         end
      end
   end

   // Receiver: a long hold when asked, otherwise stall patterns that change now and then
   initial begin
      int mode;
      int mode_left;
      mode = 0;
      mode_left = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ready = 1'b0;
            hold_cycles--;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(5, 60);
            end
            mode_left--;
            case (mode)
               0: rsp_ready = 1'b1;
               1: rsp_ready = ($urandom_range(0, 3) != 0);
               2: rsp_ready = ($urandom_range(0, 3) == 0);
               default: rsp_ready = ((mode_left % 6) < 3);
            endcase
         end
      end
   end

   task automatic send_request(input logic [7:0] b, input logic e);
      int gap;
      gap = 0;
      if (pace_on) begin
         if (burst_left == 0) begin
            gap        = $urandom_range(1, 10);
            burst_left = $urandom_range(1, 24);
         end else begin
            burst_left--;
         end
      end
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data_byte  = b;
      req_end_marker = e;
      req_valid      = 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_item(b, e);
      items_sent++;
   endtask

   task automatic close_file();
      send_request(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic send_noise(input int n);
      repeat (n) send_request(8'($urandom_range(0, 255)), 1'b0);
   endtask

   task automatic send_preamble(input logic [31:0] count);
      send_noise(int'(bstl_pkg::HEADER_BYTES));
      for (int i = 0; i < 4; i++)
         send_request(count[8 * i +: 8], 1'b0);
   endtask

   // coords[0..2] = corner 0 x,y,z, and so on; normal and attribute are random
   task automatic send_record(input logic [8:0][31:0] coords);
      send_noise(int'(bstl_pkg::NORMAL_BYTES));
      for (int w = 0; w < 9; w++)
         for (int i = 0; i < 4; i++)
            send_request(coords[w][8 * i +: 8], 1'b0);
      send_noise(2);
   endtask

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7F80_0000;
         default: return $urandom();
      endcase
   endfunction

   task automatic send_random_records(input int n);
      logic [8:0][31:0] c;
      for (int r = 0; r < n; r++) begin
         for (int i = 0; i < 9; i++)
            c[i] = pick_coord();
         send_record(c);
      end
   endtask

   // Drop valid and wait until every predicted result has been checked
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic test_short_files();
      pace_on = 1'b1;
      send_request(8'hFF, 1'b1);
      send_noise(int'(bstl_pkg::HEADER_BYTES));
      send_request(8'hFF, 1'b0);
      send_request(8'hFF, 1'b0);
      send_request(8'hFF, 1'b0);
      close_file();
      drain();
   endtask

   task automatic test_empty_files();
      send_preamble(32'd0);
      send_request(8'h00, 1'b1);
      send_preamble(32'd0);
      send_request(8'hA5, 1'b0);
      close_file();
      drain();
   endtask

   task automatic test_extreme_vertices();
      send_preamble(32'd3);
      send_record({9{32'hFFFF_FFFF}});
      send_record({9{32'h0000_0000}});
      send_record({32'h7F80_0000, 32'h8000_0000, 32'h0000_0001, 32'hFF80_0000,
                   32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0102_0304,
                   32'hFEDC_BA98});
      close_file();
      drain();
   endtask

   task automatic test_truncation_and_excess();
      send_preamble(32'hFFFF_FFFF);
      send_random_records(1);
      close_file();
      send_preamble(32'd3);
      send_random_records(1);
      send_noise(20);
      close_file();
      drain();
   endtask

   task automatic test_backpressure();
      pace_on     = 1'b0;
      hold_cycles = 300;
      send_preamble(32'd3);
      send_random_records(3);
      close_file();
      drain();
      pace_on = 1'b1;
   endtask

   task automatic test_random_files();
      int stop_at;
      int shape;
      int n;
      int k;
      stop_at = 1100;
      while (items_sent < stop_at) begin
         pace_on = ($urandom_range(0, 3) != 0);
         shape   = $urandom_range(0, 99);
         n       = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 4);
         if (shape < 60) begin
            send_preamble(32'(n));
            send_random_records(n);
         end else if (shape < 70) begin
            send_noise($urandom_range(0, int'(bstl_pkg::PREAMBLE_BYTES) - 1));
         end else if (shape < 78) begin
            send_preamble(32'(n % 3));
            send_random_records(n % 3);
            send_noise($urandom_range(1, 60));
         end else if (shape < 90) begin
            n = (n == 0) ? 1 : n;
            k = $urandom_range(0, n - 1);
            send_preamble(32'(n));
            send_random_records(k);
            send_noise($urandom_range(0, int'(bstl_pkg::RECORD_BYTES) - 1));
         end else begin
            send_preamble($urandom());
            send_random_records($urandom_range(0, 2));
            send_noise($urandom_range(0, 49));
         end
         close_file();
      end
      drain();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_short_files();
      test_empty_files();
      test_extreme_vertices();
      test_truncation_and_excess();
      test_backpressure();
      test_random_files();
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+hdl
hdl/bstl_pkg.sv
hdl/bstl_parser.sv
hdl/bstl_outbuf.sv
hdl/binary_stl_deframer.sv
tb/tb_top.sv
